// ===== src/hbe_pkg.sv =====
// Shared constants, payload types and command codes of the Huffman byte encoder.
`timescale 1ns / 1ps
package hbe_pkg;

   localparam int SYMBOL_COUNT  = 256;
   localparam int NODE_COUNT    = 511;
   localparam int MAX_CODE_BITS = 32;
   localparam int COUNT_BITS    = 32;

   localparam int CODE_LIMIT  = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
   localparam int ID_BASE     = SYMBOL_COUNT - 1;
   localparam int INNER_COUNT = NODE_COUNT - SYMBOL_COUNT;
   localparam int SYM_AW      = $clog2(SYMBOL_COUNT);
   localparam int NODE_AW     = $clog2(NODE_COUNT);
   localparam int INNER_AW    = $clog2(INNER_COUNT);
   localparam int ID_W        = 8;
   localparam int NODE_W      = ID_W + 1;
   localparam int CODE_W      = 32;
   localparam int CODE_AW     = $clog2(CODE_W);
   localparam int LEN_W       = $clog2(CODE_LIMIT + 1);
   localparam int CODE_RAM_W  = LEN_W + CODE_W;
   localparam int ALPHA_W     = $clog2(SYMBOL_COUNT + 1);
   localparam int RES_DEPTH   = 4;
   localparam int RES_AW      = $clog2(RES_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [3:0] HDR_TREE = 4'd8;
   localparam logic [3:0] HDR_DONE = 4'd9;

   typedef enum logic [2:0] {
      KIND_COUNT  = 3'd0,
      KIND_BUILD  = 3'd1,
      KIND_PULL   = 3'd2,
      KIND_ENCODE = 3'd3,
      KIND_FLUSH  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       header_done;
      logic       error;
   } rsp_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] symbol;
   } qentry_type;

   typedef struct packed {
      logic       valid;
      qentry_type entry;
   } qhead_type;

   typedef struct packed {
      logic clearing;
   } status_type;

endpackage

// ===== src/hbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/hbe_front.sv =====
// Front end: accepts commands, classifies them and queues them for the engine.
`timescale 1ns / 1ps
module hbe_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  hbe_pkg::req_type       req_data,
   input  hbe_pkg::status_type    status,
   input  logic                   q_pop,
   output logic                   busy,
   output hbe_pkg::qhead_type     q_head
);

   hbe_pkg::qentry_type entry_ff [hbe_pkg::QUEUE_DEPTH];
   logic [hbe_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic [hbe_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hbe_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   hbe_pkg::kind_type kind;
   logic known;
   logic sym_ok;
   logic push;

   assign sym_ok = ({1'b0, req_data.symbol} < 9'(hbe_pkg::SYMBOL_COUNT));

   always_comb begin
      kind  = hbe_pkg::KIND_COUNT;
      known = 1'b0;
      unique case (req_data.kind)
         hbe_pkg::KIND_COUNT: begin
            kind  = hbe_pkg::KIND_COUNT;
            known = sym_ok;
         end
         hbe_pkg::KIND_BUILD: begin
            kind  = hbe_pkg::KIND_BUILD;
            known = 1'b1;
         end
         hbe_pkg::KIND_PULL: begin
            kind  = hbe_pkg::KIND_PULL;
            known = 1'b1;
         end
         hbe_pkg::KIND_ENCODE: begin
            kind  = hbe_pkg::KIND_ENCODE;
            known = sym_ok;
         end
         hbe_pkg::KIND_FLUSH: begin
            kind  = hbe_pkg::KIND_FLUSH;
            known = 1'b1;
         end
         default: begin
            kind  = hbe_pkg::KIND_COUNT;
            known = 1'b0;
         end
      endcase
   end

   assign busy = (count_ff == (hbe_pkg::QUEUE_AW + 1)'(hbe_pkg::QUEUE_DEPTH)) || status.clearing;
   assign push = start && !busy && known;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{kind: kind, symbol: req_data.symbol};
      end
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.entry = entry_ff[rd_ptr_ff];

endmodule

// ===== src/hbe_back.sv =====
// Back end: histogram, tree build, code table, header dump and bit packing.
`timescale 1ns / 1ps
module hbe_back (
   input  logic                clock,
   input  logic                reset,
   input  hbe_pkg::qhead_type  q_head,
   output logic                q_pop,
   output hbe_pkg::status_type status,
   output logic                rsp_strobe,
   output hbe_pkg::rsp_type    rsp_data
);

   typedef enum logic [24:0] {
      S_CLEAR    = 25'b1 << 0,
      S_IDLE     = 25'b1 << 1,
      S_CNT_WR   = 25'b1 << 2,
      S_ENC_LD   = 25'b1 << 3,
      S_PUT      = 25'b1 << 4,
      S_FIN      = 25'b1 << 5,
      S_DRAIN    = 25'b1 << 6,
      S_B_CLR    = 25'b1 << 7,
      S_B_NEXT   = 25'b1 << 8,
      S_B_RD     = 25'b1 << 9,
      S_B_USE    = 25'b1 << 10,
      S_B_SUM    = 25'b1 << 11,
      S_B_LINKA  = 25'b1 << 12,
      S_C_RD     = 25'b1 << 13,
      S_C_USE    = 25'b1 << 14,
      S_C_WR     = 25'b1 << 15,
      S_L_RD     = 25'b1 << 16,
      S_L_USE    = 25'b1 << 17,
      S_D_HEAD   = 25'b1 << 18,
      S_D_RD     = 25'b1 << 19,
      S_D_USE    = 25'b1 << 20,
      S_D_ACT    = 25'b1 << 21,
      S_D_LEAF   = 25'b1 << 22,
      S_D_CL_RD  = 25'b1 << 23,
      S_D_CL_USE = 25'b1 << 24
   } state_type;

   localparam int CW  = hbe_pkg::COUNT_BITS;
   localparam int NAW = hbe_pkg::NODE_AW;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [NAW-1:0]                 idx_ff, idx_in;
   logic [NAW-1:0]                 i_ff, i_in;
   logic [hbe_pkg::SYM_AW-1:0]     s_ff, s_in;
   logic [NAW-1:0]                 a_ff, a_in, b_ff, b_in;
   logic [CW-1:0]                  wa_ff, wa_in, wb_ff, wb_in;
   logic                           a_v_ff, a_v_in, b_v_ff, b_v_in;
   logic [hbe_pkg::CODE_W-1:0]     cw_ff, cw_in;
   logic [hbe_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [CW-1:0]                  total_ff, total_in;
   logic [hbe_pkg::ALPHA_W-1:0]    alpha_ff, alpha_in;
   logic [7:0]                     buf_ff, buf_in;
   logic [2:0]                     fill_ff, fill_in;
   logic [hbe_pkg::ID_W-1:0]       dump_ff, dump_in;
   logic                           right_ff, right_in;
   logic [3:0]                     hdr_ff, hdr_in;
   logic                           err_ff, err_in;
   logic [hbe_pkg::CODE_W-1:0]     put_src_ff, put_src_in;
   logic [hbe_pkg::LEN_W-1:0]      put_cnt_ff, put_cnt_in;
   logic [7:0]                     res_ff [hbe_pkg::RES_DEPTH];
   logic [7:0]                     res_in [hbe_pkg::RES_DEPTH];
   logic [hbe_pkg::RES_AW:0]       res_cnt_ff, res_cnt_in;
   logic [hbe_pkg::RES_AW-1:0]     drain_ff, drain_in;
   hbe_pkg::kind_type              kind_ff, kind_in;
   logic [hbe_pkg::SYM_AW-1:0]     sym_ff, sym_in;
   logic                           pend_ff, pend_in;

   logic                           cnt_we;
   logic [hbe_pkg::SYM_AW-1:0]     cnt_waddr, cnt_raddr;
   logic [CW-1:0]                  cnt_wdata, cnt_rd;
   logic                           inw_we;
   logic [hbe_pkg::INNER_AW-1:0]   inw_waddr, inw_raddr;
   logic [CW-1:0]                  inw_wdata, inw_rd;
   logic                           node_we;
   logic [NAW-1:0]                 node_waddr, node_raddr;
   logic [hbe_pkg::NODE_W-1:0]     node_wdata, node_rd;
   logic                           code_we;
   logic [hbe_pkg::SYM_AW-1:0]     code_waddr, code_raddr;
   logic [hbe_pkg::CODE_RAM_W-1:0] code_wdata, code_rd;

   logic                           emit_en;
   logic [7:0]                     emit_byte;
   logic [hbe_pkg::ID_W-1:0]       node_par;
   logic                           node_bit;
   logic [CW-1:0]                  weight;
   logic [CW:0]                    sum;
   logic [NAW:0]                   lim;
   logic [hbe_pkg::LEN_W-1:0]      put_dec;
   logic                           put_bit;
   logic [7:0]                     put_byte;
   logic [63:0]                    total_wide;
   logic [hbe_pkg::SYM_AW-1:0]     low_sym;
   logic                           leaf;
   logic                           drain_last;
   logic [hbe_pkg::ID_W-1:0]       new_id;

   hbe_ram #(.WIDTH(CW), .DEPTH(hbe_pkg::SYMBOL_COUNT)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rd)
   );

   hbe_ram #(.WIDTH(CW), .DEPTH(hbe_pkg::INNER_COUNT)) u_inw_ram (
      .clock(clock), .wr_en(inw_we), .wr_addr(inw_waddr), .wr_data(inw_wdata),
      .rd_addr(inw_raddr), .rd_data(inw_rd)
   );

   hbe_ram #(.WIDTH(hbe_pkg::NODE_W), .DEPTH(hbe_pkg::NODE_COUNT)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_waddr), .wr_data(node_wdata),
      .rd_addr(node_raddr), .rd_data(node_rd)
   );

   hbe_ram #(.WIDTH(hbe_pkg::CODE_RAM_W), .DEPTH(hbe_pkg::SYMBOL_COUNT)) u_code_ram (
      .clock(clock), .wr_en(code_we), .wr_addr(code_waddr), .wr_data(code_wdata),
      .rd_addr(code_raddr), .rd_data(code_rd)
   );

   assign node_par   = node_rd[hbe_pkg::ID_W-1:0];
   assign node_bit   = node_rd[hbe_pkg::ID_W];
   assign weight     = (idx_ff < NAW'(hbe_pkg::SYMBOL_COUNT)) ? cnt_rd : inw_rd;
   assign sum        = {1'b0, wa_ff} + {1'b0, wb_ff};
   assign lim        = (NAW + 1)'(hbe_pkg::ID_BASE) + (NAW + 1)'(alpha_ff);
   assign put_dec    = put_cnt_ff - 1'b1;
   assign put_bit    = put_src_ff[put_dec[hbe_pkg::CODE_AW-1:0]];
   assign put_byte   = {buf_ff[6:0], put_bit};
   assign total_wide = 64'(total_ff);
   assign low_sym    = (cnt_rd != '0) ? s_ff : '0;
   assign leaf       = (idx_ff < NAW'(hbe_pkg::SYMBOL_COUNT));
   assign drain_last = (({1'b0, drain_ff} + 1'b1) == res_cnt_ff);
   assign new_id     = hbe_pkg::ID_W'(i_ff - NAW'(hbe_pkg::ID_BASE));

   assign q_pop           = (state_ff == S_IDLE) && q_head.valid;
   assign status.clearing = (state_ff == S_CLEAR);

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      idx_in     = idx_ff;
      i_in       = i_ff;
      s_in       = s_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      wa_in      = wa_ff;
      wb_in      = wb_ff;
      a_v_in     = a_v_ff;
      b_v_in     = b_v_ff;
      cw_in      = cw_ff;
      len_in     = len_ff;
      total_in   = total_ff;
      alpha_in   = alpha_ff;
      buf_in     = buf_ff;
      fill_in    = fill_ff;
      dump_in    = dump_ff;
      right_in   = right_ff;
      hdr_in     = hdr_ff;
      err_in     = err_ff;
      put_src_in = put_src_ff;
      put_cnt_in = put_cnt_ff;
      res_in     = res_ff;
      res_cnt_in = res_cnt_ff;
      drain_in   = drain_ff;
      kind_in    = kind_ff;
      sym_in     = sym_ff;
      pend_in    = pend_ff;
      emit_en    = 1'b0;
      emit_byte  = '0;

      cnt_we     = 1'b0;
      cnt_waddr  = sym_ff;
      cnt_wdata  = '0;
      cnt_raddr  = s_ff;
      inw_we     = 1'b0;
      inw_waddr  = hbe_pkg::INNER_AW'(i_ff - NAW'(hbe_pkg::SYMBOL_COUNT));
      inw_wdata  = '0;
      inw_raddr  = '0;
      node_we    = 1'b0;
      node_waddr = idx_ff;
      node_wdata = '0;
      node_raddr = idx_ff;
      code_we    = 1'b0;
      code_waddr = s_ff;
      code_wdata = '0;
      code_raddr = q_head.entry.symbol[hbe_pkg::SYM_AW-1:0];

      rsp_strobe = 1'b0;
      rsp_data   = '0;

      unique case (state_ff)
         S_CLEAR: begin
            node_we = 1'b1;
            if (idx_ff < NAW'(hbe_pkg::SYMBOL_COUNT)) begin
               cnt_we     = 1'b1;
               cnt_waddr  = idx_ff[hbe_pkg::SYM_AW-1:0];
               code_we    = 1'b1;
               code_waddr = idx_ff[hbe_pkg::SYM_AW-1:0];
            end
            if (idx_ff == NAW'(hbe_pkg::NODE_COUNT - 1)) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_IDLE: begin
            cnt_raddr = q_head.entry.symbol[hbe_pkg::SYM_AW-1:0];
            if (q_head.valid) begin
               kind_in = q_head.entry.kind;
               sym_in  = q_head.entry.symbol[hbe_pkg::SYM_AW-1:0];
               unique case (q_head.entry.kind)
                  hbe_pkg::KIND_COUNT: begin
                     state_in = S_CNT_WR;
                  end
                  hbe_pkg::KIND_BUILD: begin
                     alpha_in = '0;
                     buf_in   = '0;
                     fill_in  = '0;
                     dump_in  = '0;
                     right_in = 1'b0;
                     hdr_in   = '0;
                     idx_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_B_CLR;
                  end
                  hbe_pkg::KIND_PULL: begin
                     if (hdr_ff < hbe_pkg::HDR_TREE) begin
                        emit_en   = 1'b1;
                        emit_byte = 8'(total_wide >> {hdr_ff[2:0], 3'b000});
                        hdr_in    = hdr_ff + 1'b1;
                        state_in  = S_DRAIN;
                        if (hdr_ff == hbe_pkg::HDR_TREE - 1'b1) begin
                           buf_in  = '0;
                           fill_in = '0;
                           if (total_ff == '0) begin
                              hdr_in = hbe_pkg::HDR_DONE;
                           end else if (total_ff[CW-1:1] != '0) begin
                              if (alpha_ff == '0) begin
                                 hdr_in = hbe_pkg::HDR_DONE;
                              end else if (alpha_ff[hbe_pkg::ALPHA_W-1:1] != '0) begin
                                 dump_in  = hbe_pkg::ID_W'(alpha_ff - 1'b1);
                                 right_in = 1'b0;
                                 fill_in  = 3'd1;
                              end
                           end
                        end
                     end else if (hdr_ff == hbe_pkg::HDR_TREE) begin
                        priority if (total_ff[CW-1:1] == '0) begin
                           if (total_ff[0]) begin
                              s_in     = '0;
                              state_in = S_L_RD;
                           end else begin
                              hdr_in = hbe_pkg::HDR_DONE;
                           end
                        end else if (alpha_ff == '0) begin
                           hdr_in = hbe_pkg::HDR_DONE;
                        end else if (alpha_ff == hbe_pkg::ALPHA_W'(1)) begin
                           s_in     = '0;
                           state_in = S_L_RD;
                        end else begin
                           state_in = S_D_HEAD;
                        end
                     end
                  end
                  hbe_pkg::KIND_ENCODE: begin
                     state_in = S_ENC_LD;
                  end
                  hbe_pkg::KIND_FLUSH: begin
                     if (fill_ff != '0) begin
                        emit_en   = 1'b1;
                        emit_byte = 8'(buf_ff << (4'd8 - {1'b0, fill_ff}));
                        buf_in    = '0;
                        fill_in   = '0;
                        state_in  = S_DRAIN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_CNT_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = sym_ff;
            if (cnt_rd == '1) begin
               cnt_wdata = cnt_rd;
               err_in    = 1'b1;
            end else begin
               cnt_wdata = cnt_rd + 1'b1;
            end
            if (total_ff == '1) begin
               err_in = 1'b1;
            end else begin
               total_in = total_ff + 1'b1;
            end
            state_in = S_IDLE;
         end

         S_ENC_LD: begin
            put_src_in = code_rd[hbe_pkg::CODE_W-1:0];
            put_cnt_in = code_rd[hbe_pkg::CODE_W +: hbe_pkg::LEN_W];
            ret_in     = S_FIN;
            state_in   = S_PUT;
         end

         S_PUT: begin
            if (put_cnt_ff == '0) begin
               state_in = ret_ff;
            end else begin
               if (fill_ff == 3'd7) begin
                  emit_en   = 1'b1;
                  emit_byte = put_byte;
                  buf_in    = '0;
                  fill_in   = '0;
               end else begin
                  buf_in  = put_byte;
                  fill_in = fill_ff + 1'b1;
               end
               put_cnt_in = put_dec;
            end
         end

         S_FIN: begin
            drain_in = '0;
            state_in = (res_cnt_ff != '0) ? S_DRAIN : S_IDLE;
         end

         S_DRAIN: begin
            rsp_strobe           = 1'b1;
            rsp_data.out_byte    = res_ff[drain_ff];
            rsp_data.last        = drain_last;
            rsp_data.header_done = (hdr_ff >= hbe_pkg::HDR_DONE) &&
                                   (drain_last || (kind_ff != hbe_pkg::KIND_PULL));
            rsp_data.error       = err_ff;
            if (drain_last) begin
               res_cnt_in = '0;
               drain_in   = '0;
               state_in   = S_IDLE;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end

         S_B_CLR: begin
            node_we   = 1'b1;
            pend_in   = (idx_ff < NAW'(hbe_pkg::SYMBOL_COUNT));
            cnt_raddr = idx_ff[hbe_pkg::SYM_AW-1:0];
            if (idx_ff < NAW'(hbe_pkg::SYMBOL_COUNT)) begin
               code_we    = 1'b1;
               code_waddr = idx_ff[hbe_pkg::SYM_AW-1:0];
            end
            if (pend_ff && (cnt_rd != '0)) begin
               alpha_in = alpha_ff + 1'b1;
            end
            if (idx_ff == NAW'(hbe_pkg::NODE_COUNT - 1)) begin
               pend_in  = 1'b0;
               i_in     = NAW'(hbe_pkg::SYMBOL_COUNT);
               state_in = S_B_NEXT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_B_NEXT: begin
            if (({1'b0, i_ff} < lim) && ({1'b0, i_ff} < (NAW + 1)'(hbe_pkg::NODE_COUNT))) begin
               a_v_in   = 1'b0;
               b_v_in   = 1'b0;
               idx_in   = '0;
               state_in = S_B_RD;
            end else begin
               s_in     = '0;
               idx_in   = '0;
               len_in   = '0;
               cw_in    = '0;
               state_in = S_C_RD;
            end
         end

         S_B_RD: begin
            cnt_raddr = idx_ff[hbe_pkg::SYM_AW-1:0];
            if (!leaf) begin
               inw_raddr = hbe_pkg::INNER_AW'(idx_ff - NAW'(hbe_pkg::SYMBOL_COUNT));
            end
            node_raddr = idx_ff;
            state_in   = S_B_USE;
         end

         S_B_USE: begin
            if ((weight != '0) && (node_par == '0)) begin
               if (!a_v_ff || (weight < wa_ff)) begin
                  b_in   = a_ff;
                  wb_in  = wa_ff;
                  b_v_in = a_v_ff;
                  a_in   = idx_ff;
                  wa_in  = weight;
                  a_v_in = 1'b1;
               end else if (!b_v_ff || (weight < wb_ff)) begin
                  b_in   = idx_ff;
                  wb_in  = weight;
                  b_v_in = 1'b1;
               end
            end
            if ((idx_ff + 1'b1) == i_ff) begin
               state_in = S_B_SUM;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_B_RD;
            end
         end

         S_B_SUM: begin
            if (!b_v_ff) begin
               s_in     = '0;
               idx_in   = '0;
               len_in   = '0;
               cw_in    = '0;
               state_in = S_C_RD;
            end else begin
               inw_we = 1'b1;
               if (sum[CW]) begin
                  inw_wdata = '1;
                  err_in    = 1'b1;
               end else begin
                  inw_wdata = sum[CW-1:0];
               end
               node_we    = 1'b1;
               node_waddr = b_ff;
               node_wdata = {1'b1, new_id};
               state_in   = S_B_LINKA;
            end
         end

         S_B_LINKA: begin
            node_we    = 1'b1;
            node_waddr = a_ff;
            node_wdata = {1'b0, new_id};
            i_in       = i_ff + 1'b1;
            state_in   = S_B_NEXT;
         end

         S_C_RD: begin
            node_raddr = idx_ff;
            state_in   = S_C_USE;
         end

         S_C_USE: begin
            if (node_par == '0) begin
               state_in = S_C_WR;
            end else if (len_ff >= hbe_pkg::LEN_W'(hbe_pkg::CODE_LIMIT)) begin
               err_in   = 1'b1;
               len_in   = '0;
               cw_in    = '0;
               state_in = S_C_WR;
            end else begin
               cw_in[len_ff[hbe_pkg::CODE_AW-1:0]] = node_bit;
               len_in   = len_ff + 1'b1;
               idx_in   = NAW'(node_par) + NAW'(hbe_pkg::ID_BASE);
               state_in = S_C_RD;
            end
         end

         S_C_WR: begin
            code_we    = 1'b1;
            code_waddr = s_ff;
            code_wdata = {len_ff, cw_ff};
            if (s_ff == hbe_pkg::SYM_AW'(hbe_pkg::SYMBOL_COUNT - 1)) begin
               state_in = S_FIN;
            end else begin
               s_in     = s_ff + 1'b1;
               idx_in   = NAW'(s_ff) + 1'b1;
               len_in   = '0;
               cw_in    = '0;
               state_in = S_C_RD;
            end
         end

         S_L_RD: begin
            cnt_raddr = s_ff;
            state_in  = S_L_USE;
         end

         S_L_USE: begin
            if ((cnt_rd != '0) || (s_ff == hbe_pkg::SYM_AW'(hbe_pkg::SYMBOL_COUNT - 1))) begin
               emit_en = 1'b1;
               hdr_in  = hbe_pkg::HDR_DONE;
               if (total_ff[CW-1:1] == '0) begin
                  emit_byte = 8'(low_sym);
               end else begin
                  emit_byte = {1'b1, 7'(low_sym >> 1)};
                  buf_in    = {7'b0, low_sym[0]};
                  fill_in   = 3'd1;
               end
               state_in = S_FIN;
            end else begin
               s_in     = s_ff + 1'b1;
               state_in = S_L_RD;
            end
         end

         S_D_HEAD: begin
            if (dump_ff == '0) begin
               hdr_in   = hbe_pkg::HDR_DONE;
               state_in = S_FIN;
            end else begin
               idx_in   = '0;
               state_in = S_D_RD;
            end
         end

         S_D_RD: begin
            if ({1'b0, idx_ff} >= lim) begin
               dump_in  = '0;
               hdr_in   = hbe_pkg::HDR_DONE;
               state_in = S_FIN;
            end else begin
               node_raddr = idx_ff;
               state_in   = S_D_USE;
            end
         end

         S_D_USE: begin
            if ((node_par == dump_ff) && (node_bit == right_ff)) begin
               state_in = S_D_ACT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_D_RD;
            end
         end

         S_D_ACT: begin
            if ((res_cnt_ff != '0) && (leaf || (fill_ff == 3'd7))) begin
               state_in = S_FIN;
            end else if (leaf) begin
               put_src_in = hbe_pkg::CODE_W'({1'b1, idx_ff[7:0]});
               put_cnt_in = hbe_pkg::LEN_W'(9);
               ret_in     = S_D_LEAF;
               state_in   = S_PUT;
            end else begin
               put_src_in = '0;
               put_cnt_in = hbe_pkg::LEN_W'(1);
               dump_in    = hbe_pkg::ID_W'(idx_ff - NAW'(hbe_pkg::ID_BASE));
               right_in   = 1'b0;
               ret_in     = S_D_HEAD;
               state_in   = S_PUT;
            end
         end

         S_D_LEAF: begin
            if (right_ff) begin
               state_in = S_D_CL_RD;
            end else begin
               right_in = 1'b1;
               state_in = S_D_HEAD;
            end
         end

         S_D_CL_RD: begin
            node_raddr = NAW'(dump_ff) + NAW'(hbe_pkg::ID_BASE);
            state_in   = S_D_CL_USE;
         end

         S_D_CL_USE: begin
            dump_in = node_par;
            if ((node_par != '0) && node_bit) begin
               state_in = S_D_CL_RD;
            end else begin
               right_in = 1'b1;
               state_in = S_D_HEAD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit_en && (res_cnt_ff < (hbe_pkg::RES_AW + 1)'(hbe_pkg::RES_DEPTH))) begin
         res_in[res_cnt_ff[hbe_pkg::RES_AW-1:0]] = emit_byte;
         res_cnt_in = res_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      i_ff       <= i_in;
      s_ff       <= s_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      wa_ff      <= wa_in;
      wb_ff      <= wb_in;
      a_v_ff     <= a_v_in;
      b_v_ff     <= b_v_in;
      cw_ff      <= cw_in;
      len_ff     <= len_in;
      put_src_ff <= put_src_in;
      put_cnt_ff <= put_cnt_in;
      res_ff     <= res_in;
      kind_ff    <= kind_in;
      sym_ff     <= sym_in;
      if (reset) begin
         state_ff   <= S_CLEAR;
         idx_ff     <= '0;
         total_ff   <= '0;
         alpha_ff   <= '0;
         buf_ff     <= '0;
         fill_ff    <= '0;
         dump_ff    <= '0;
         right_ff   <= 1'b0;
         hdr_ff     <= '0;
         err_ff     <= 1'b0;
         res_cnt_ff <= '0;
         drain_ff   <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         total_ff   <= total_in;
         alpha_ff   <= alpha_in;
         buf_ff     <= buf_in;
         fill_ff    <= fill_in;
         dump_ff    <= dump_in;
         right_ff   <= right_in;
         hdr_ff     <= hdr_in;
         err_ff     <= err_in;
         res_cnt_ff <= res_cnt_in;
         drain_ff   <= drain_in;
         pend_ff    <= pend_in;
      end
   end

   a_dump_in_tree: assert property (@(posedge clock) disable iff (reset)
      (dump_ff != '0) |-> (hdr_ff == hbe_pkg::HDR_TREE))
      else $error("tree walk active outside the tree phase");

   a_hdr_bound: assert property (@(posedge clock) disable iff (reset)
      hdr_ff <= hbe_pkg::HDR_DONE)
      else $error("header index beyond done");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> (res_cnt_ff != '0))
      else $error("drain with no buffered bytes");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DRAIN) && drain_last) |=> ((res_cnt_ff == '0) && (state_ff == S_IDLE)))
      else $error("result buffer not released after last transfer");

endmodule

// ===== src/huffman_byte_encoder.sv =====
// Top level of the two-pass static Huffman byte encoder.
// Pull: tree pulls walk the node RAM.
// Build: clear of all 511 nodes, then per inner node a scan of all earlier nodes,
// then a node RAM read per code bit for each of 256 symbols.
// Throughput: one command at a time in the engine, two more held in the command queue.
// Reset: counts, code table and node RAM are swept to zero; busy stays high meanwhile.
`timescale 1ns / 1ps
module huffman_byte_encoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hbe_pkg::req_type req_data,
   output logic             rsp_strobe,
   output hbe_pkg::rsp_type rsp_data
);

   hbe_pkg::qhead_type  q_head;
   hbe_pkg::status_type status;
   logic                q_pop;

   hbe_front u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .status(status),
      .q_pop(q_pop),
      .busy(busy),
      .q_head(q_head)
   );

   hbe_back u_back (
      .clock(clock),
      .reset(reset),
      .q_head(q_head),
      .q_pop(q_pop),
      .status(status),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

endmodule
